// ===== rtl/joystick_dead_zone_and_thrust_top_defines.svh =====
// Assertion helpers for the gamepad conditioning block.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef JOYSTICK_DEAD_ZONE_AND_THRUST_TOP_DEFINES_SVH
`define JOYSTICK_DEAD_ZONE_AND_THRUST_TOP_DEFINES_SVH

// Same-cycle implication.
`define JDZT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JDZT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jdzt_pkg.sv =====
`default_nettype none

package jdzt_pkg;

  localparam int unsigned Q15_W  = 16;
  localparam int unsigned DZ_W   = 15;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // divider: 16 quotient bits per division
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CNT_W     = 4;

  localparam logic [Q15_W:0]     Q15_ONE    = 17'd32768;
  localparam logic [Q15_W:0]     Q15_TWO    = 17'd65536;
  localparam logic [Q15_W-1:0]   Q15_MAX    = 16'h7FFF;
  localparam logic [Q15_W-1:0]   THRUST_FULL = 16'h8000;

  localparam logic [DZ_W-1:0]    PITCH_DZ_RST = 15'd6554;
  localparam logic [DZ_W-1:0]    YAW_DZ_RST   = 15'd9830;
  localparam logic [DZ_W-1:0]    ROLL_DZ_RST  = 15'd3277;
  localparam logic [STEP_W-1:0]  STEP_RST     = 16'd3277;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_DZ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_DZ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_DZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } jdzt_state_e;

  typedef enum logic [1:0] {
    OP_PITCH = 2'd0,
    OP_ROLL  = 2'd1,
    OP_YAW_L = 2'd2,
    OP_YAW_R = 2'd3
  } jdzt_op_e;

endpackage

`default_nettype wire

// ===== rtl/joystick_dead_zone_and_thrust_top.sv =====
// Gamepad conditioning: one poll in, one conditioned command out.
// Input channel: in_valid_i / in_stall_o with the four axes and five buttons.
// Output channel: out_valid_o / out_stall_i with pitch, yaw, roll, thrust, fire.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 pitch dead zone, 1 trigger dead zone, 2 roll dead zone, 3 thrust step);
// other indexes are ignored. Write only while the block is idle.
// One serial restoring divider yields one quotient bit per cycle and is
// shared by the four axis mappings: each runs a setup state and then 16 steps.
// out_valid_o rises and the input side opens again at the same edge, when
// the done state hands the result to the output register.
// The result sits in an output register; while it waits under out_stall_i
// the next poll is accepted and computed, then waits in the done state
// until the output register frees up.
// Reset clears the thrust level, button history and output valid flag, and
// loads the register defaults; no clearing pass is needed.
`default_nettype none

`include "joystick_dead_zone_and_thrust_top_defines.svh"

module joystick_dead_zone_and_thrust_top #(
  parameter int unsigned AXIS_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [jdzt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [jdzt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [AXIS_WIDTH-1:0]         axis_roll_i,
  input  wire logic signed [AXIS_WIDTH-1:0]         axis_pitch_i,
  input  wire logic signed [AXIS_WIDTH-1:0]         axis_yaw_left_i,
  input  wire logic signed [AXIS_WIDTH-1:0]         axis_yaw_right_i,
  input  wire logic                                 btn_thrust_down_i,
  input  wire logic                                 btn_thrust_up_i,
  input  wire logic                                 btn_thrust_zero_i,
  input  wire logic                                 btn_thrust_full_i,
  input  wire logic                                 btn_fire_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [jdzt_pkg::Q15_W-1:0]         pitch_out_o,
  output logic signed [jdzt_pkg::Q15_W-1:0]         yaw_out_o,
  output logic signed [jdzt_pkg::Q15_W-1:0]         roll_out_o,
  output logic [jdzt_pkg::Q15_W-1:0]                thrust_out_o,
  output logic                                      fire_out_o
);

  localparam int unsigned QW = jdzt_pkg::Q15_W;

  // Q15 views of the axes
  logic [QW-1:0] roll_q15, pitch_q15, yl_q15, yr_q15;

  if (AXIS_WIDTH >= QW) begin : g_trunc
    assign roll_q15  = axis_roll_i[AXIS_WIDTH-1 -: QW];
    assign pitch_q15 = axis_pitch_i[AXIS_WIDTH-1 -: QW];
    assign yl_q15    = axis_yaw_left_i[AXIS_WIDTH-1 -: QW];
    assign yr_q15    = axis_yaw_right_i[AXIS_WIDTH-1 -: QW];
  end else begin : g_pad
    localparam int unsigned PadW = QW - AXIS_WIDTH;
    assign roll_q15  = {axis_roll_i, {PadW{1'b0}}};
    assign pitch_q15 = {axis_pitch_i, {PadW{1'b0}}};
    assign yl_q15    = {axis_yaw_left_i, {PadW{1'b0}}};
    assign yr_q15    = {axis_yaw_right_i, {PadW{1'b0}}};
  end

  // configuration registers
  logic [jdzt_pkg::DZ_W-1:0]   pitch_dz_q, yaw_dz_q, roll_dz_q;
  logic [jdzt_pkg::STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_dz_q <= jdzt_pkg::PITCH_DZ_RST;
      yaw_dz_q   <= jdzt_pkg::YAW_DZ_RST;
      roll_dz_q  <= jdzt_pkg::ROLL_DZ_RST;
      step_q     <= jdzt_pkg::STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jdzt_pkg::REG_PITCH_DZ: pitch_dz_q <= cfg_data_i[jdzt_pkg::DZ_W-1:0];
        jdzt_pkg::REG_YAW_DZ:   yaw_dz_q   <= cfg_data_i[jdzt_pkg::DZ_W-1:0];
        jdzt_pkg::REG_ROLL_DZ:  roll_dz_q  <= cfg_data_i[jdzt_pkg::DZ_W-1:0];
        jdzt_pkg::REG_STEP:     step_q     <= cfg_data_i[jdzt_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  jdzt_pkg::jdzt_state_e state_q, state_d;
  jdzt_pkg::jdzt_op_e    op_q, op_d;
  logic [jdzt_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic in_acc, out_load;
  assign in_stall_o = (state_q != jdzt_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == jdzt_pkg::S_DONE) && (!out_valid_o || !out_stall_i);

  // captured poll
  logic [QW-1:0] roll_q, pitch_q, yl_q, yr_q;
  logic          fire_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      roll_q  <= roll_q15;
      pitch_q <= pitch_q15;
      yl_q    <= yl_q15;
      yr_q    <= yr_q15;
      fire_q  <= btn_fire_i;
    end
  end

  // thrust lever, updated on the accepting edge
  logic [QW-1:0] thrust_q, thrust_d, lvl_dn;
  logic [QW:0]   lvl_up;
  logic          down_held_q, up_held_q;

  always_comb begin
    lvl_dn = thrust_q;
    if (btn_thrust_down_i && !down_held_q) begin
      lvl_dn = (thrust_q < step_q) ? '0 : thrust_q - step_q;
    end
    lvl_up = {1'b0, lvl_dn};
    if (btn_thrust_up_i && !up_held_q) begin
      lvl_up = {1'b0, lvl_dn} + {1'b0, step_q};
    end
    priority if (btn_thrust_full_i) begin
      thrust_d = jdzt_pkg::THRUST_FULL;
    end else if (btn_thrust_zero_i) begin
      thrust_d = '0;
    end else if (lvl_up > jdzt_pkg::Q15_ONE) begin
      thrust_d = jdzt_pkg::THRUST_FULL;
    end else begin
      thrust_d = lvl_up[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thrust_q    <= '0;
      down_held_q <= 1'b0;
      up_held_q   <= 1'b0;
    end else if (in_acc) begin
      thrust_q    <= thrust_d;
      down_held_q <= btn_thrust_down_i;
      up_held_q   <= btn_thrust_up_i;
    end
  end

  // operand setup for the current mapping
  logic [QW-1:0]          sel_v;
  logic [jdzt_pkg::DZ_W-1:0] sel_t;
  logic signed [QW:0]     c_sum, c_dif;
  logic signed [QW+1:0]   l_num;
  logic [QW-1:0]          l_ofs;
  logic [QW:0]            set_mag, set_den;
  logic                   set_neg;

  always_comb begin
    unique case (op_q)
      jdzt_pkg::OP_PITCH: begin sel_v = pitch_q; sel_t = pitch_dz_q; end
      jdzt_pkg::OP_ROLL:  begin sel_v = roll_q;  sel_t = roll_dz_q;  end
      jdzt_pkg::OP_YAW_L: begin sel_v = yl_q;    sel_t = yaw_dz_q;   end
      default:            begin sel_v = yr_q;    sel_t = yaw_dz_q;   end
    endcase
    c_sum = $signed({sel_v[QW-1], sel_v}) + $signed({2'b00, sel_t});
    c_dif = $signed({sel_v[QW-1], sel_v}) - $signed({2'b00, sel_t});
    l_num = $signed({sel_v[QW-1], sel_v, 1'b0}) - $signed({3'b000, sel_t});
    l_ofs = {~sel_v[QW-1], sel_v[QW-2:0]};
    if (op_q == jdzt_pkg::OP_PITCH || op_q == jdzt_pkg::OP_ROLL) begin
      set_den = jdzt_pkg::Q15_ONE - {2'b00, sel_t};
      priority if (c_sum[QW]) begin
        set_mag = (~c_sum) + 1'b1;
        set_neg = 1'b1;
      end else if (c_dif[QW]) begin
        set_mag = '0;
        set_neg = 1'b0;
      end else begin
        set_mag = c_dif;
        set_neg = 1'b0;
      end
    end else begin
      set_den = jdzt_pkg::Q15_TWO - {2'b00, sel_t};
      priority if (l_ofs < {1'b0, sel_t}) begin
        // below the travel floor: force -1.0 through the divider
        set_mag = set_den;
        set_neg = 1'b1;
      end else if (l_num[QW+1]) begin
        set_mag = (~l_num[QW:0]) + 1'b1;
        set_neg = 1'b1;
      end else begin
        set_mag = l_num[QW:0];
        set_neg = 1'b0;
      end
    end
  end

  // serial restoring divider: (mag << 15) / den, 16 quotient bits
  logic [QW:0]   rem_q, rem_d, den_q;
  logic [QW-1:0] nb_q, quo_q, quo_d;
  logic          neg_q;
  logic [QW+1:0] trial, diff;
  logic          ge;
  logic [QW-1:0] res_val;

  assign trial = {rem_q, nb_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = !diff[QW+1];
  assign rem_d = ge ? diff[QW:0] : trial[QW:0];
  assign quo_d = {quo_q[QW-2:0], ge};
  assign res_val = neg_q ? (~quo_d) + 1'b1 : (quo_d[QW-1] ? jdzt_pkg::Q15_MAX : quo_d);

  logic [QW-1:0] res_q [4];

  always_ff @(posedge clk_i) begin
    if (state_q == jdzt_pkg::S_SETUP) begin
      rem_q <= {1'b0, set_mag[QW:1]};
      nb_q  <= {set_mag[0], {(QW-1){1'b0}}};
      den_q <= set_den;
      neg_q <= set_neg;
      quo_q <= '0;
    end else if (state_q == jdzt_pkg::S_DIV) begin
      rem_q <= rem_d;
      nb_q  <= {nb_q[QW-2:0], 1'b0};
      quo_q <= quo_d;
      if (cnt_q == '0) begin
        res_q[op_q] <= res_val;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      jdzt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = jdzt_pkg::S_SETUP;
          op_d    = jdzt_pkg::OP_PITCH;
        end
      end
      jdzt_pkg::S_SETUP: begin
        state_d = jdzt_pkg::S_DIV;
        cnt_d   = jdzt_pkg::CNT_W'(jdzt_pkg::DIV_STEPS - 1);
      end
      jdzt_pkg::S_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (op_q == jdzt_pkg::OP_YAW_R) begin
            state_d = jdzt_pkg::S_DONE;
          end else begin
            state_d = jdzt_pkg::S_SETUP;
            op_d    = jdzt_pkg::jdzt_op_e'(op_q + 2'd1);
          end
        end
      end
      jdzt_pkg::S_DONE: begin
        if (out_load) state_d = jdzt_pkg::S_IDLE;
      end
      default: state_d = jdzt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jdzt_pkg::S_IDLE;
      op_q    <= jdzt_pkg::OP_PITCH;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  // yaw: half of (right - left), rounded toward minus infinity
  logic signed [QW:0] yaw_diff;
  assign yaw_diff = $signed({res_q[jdzt_pkg::OP_YAW_R][QW-1], res_q[jdzt_pkg::OP_YAW_R]})
                  - $signed({res_q[jdzt_pkg::OP_YAW_L][QW-1], res_q[jdzt_pkg::OP_YAW_L]});

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pitch_out_o  <= res_q[jdzt_pkg::OP_PITCH];
      roll_out_o   <= res_q[jdzt_pkg::OP_ROLL];
      yaw_out_o    <= yaw_diff[QW:1];
      thrust_out_o <= thrust_q;
      fire_out_o   <= fire_q;
    end
  end

  `JDZT_ASSERT_NEXT(a_accept_starts, in_acc, state_q == jdzt_pkg::S_SETUP,
                    "accept did not start setup")
  `JDZT_ASSERT_NOW(a_rem_below_den, state_q == jdzt_pkg::S_DIV, rem_q < den_q,
                   "remainder not below divisor")
  `JDZT_ASSERT_NOW(a_thrust_range, 1'b1, thrust_q <= jdzt_pkg::THRUST_FULL,
                   "thrust above full scale")
  `JDZT_ASSERT_NOW(a_done_last_op, state_q == jdzt_pkg::S_DONE,
                   op_q == jdzt_pkg::OP_YAW_R, "finished before last axis")
  `JDZT_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_o, "result load lost")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned AW          = 16;
  localparam longint      Q_ONE       = 32768;
  localparam int unsigned POLL_CYCLES = 70;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned QUIET_TAIL  = 60;

  localparam logic [jdzt_pkg::DZ_W-1:0]   PITCH_DZ_DEFAULT = 15'd6554;
  localparam logic [jdzt_pkg::DZ_W-1:0]   YAW_DZ_DEFAULT   = 15'd9830;
  localparam logic [jdzt_pkg::DZ_W-1:0]   ROLL_DZ_DEFAULT  = 15'd3277;
  localparam logic [jdzt_pkg::STEP_W-1:0] STEP_DEFAULT     = 16'd3277;

  localparam logic [jdzt_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = jdzt_pkg::REG_STEP + 1'b1;
  localparam logic [jdzt_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = {jdzt_pkg::CFG_IDX_W{1'b1}};

  typedef struct {
    logic signed [AW-1:0] roll, pitch, yaw_l, yaw_r;
    logic                 down, up, zero, full, fire;
  } poll_t;

  typedef struct {
    logic signed [jdzt_pkg::Q15_W-1:0] pitch, yaw, roll;
    logic [jdzt_pkg::Q15_W-1:0]        thrust;
    logic                              fire;
  } command_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_we   = 1'b0;
  logic [jdzt_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [jdzt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic signed [AW-1:0] axis_roll  = '0;
  logic signed [AW-1:0] axis_pitch = '0;
  logic signed [AW-1:0] axis_yl    = '0;
  logic signed [AW-1:0] axis_yr    = '0;
  logic                 btn_down   = 1'b0;
  logic                 btn_up     = 1'b0;
  logic                 btn_zero   = 1'b0;
  logic                 btn_full   = 1'b0;
  logic                 btn_fire   = 1'b0;

  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [jdzt_pkg::Q15_W-1:0] pitch_out, yaw_out, roll_out;
  logic [jdzt_pkg::Q15_W-1:0]        thrust_out;
  logic                              fire_out;

  // predictor copy of the registers and the thrust lever
  logic [jdzt_pkg::DZ_W-1:0]   pitch_dz    = PITCH_DZ_DEFAULT;
  logic [jdzt_pkg::DZ_W-1:0]   yaw_dz      = YAW_DZ_DEFAULT;
  logic [jdzt_pkg::DZ_W-1:0]   roll_dz     = ROLL_DZ_DEFAULT;
  logic [jdzt_pkg::STEP_W-1:0] thrust_step = STEP_DEFAULT;
  longint                      thrust_lvl  = 0;
  logic                        down_held   = 1'b0;
  logic                        up_held     = 1'b0;

  poll_t    pending_polls[$];
  command_t owed_commands[$];
  poll_t    cur;

  logic gen_down   = 1'b0;
  logic gen_up     = 1'b0;
  bit   quiet      = 1'b0;
  bit   hold_armed = 1'b0;
  bit   hold_done  = 1'b0;

  int gap_left   = 0;
  int burst_left = 0;
  int hold_left  = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int n_errors   = 0;

  joystick_dead_zone_and_thrust_top #(
    .AXIS_WIDTH(AW)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .axis_roll_i      (axis_roll),
    .axis_pitch_i     (axis_pitch),
    .axis_yaw_left_i  (axis_yl),
    .axis_yaw_right_i (axis_yr),
    .btn_thrust_down_i(btn_down),
    .btn_thrust_up_i  (btn_up),
    .btn_thrust_zero_i(btn_zero),
    .btn_thrust_full_i(btn_full),
    .btn_fire_i       (btn_fire),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pitch_out_o      (pitch_out),
    .yaw_out_o        (yaw_out),
    .roll_out_o       (roll_out),
    .thrust_out_o     (thrust_out),
    .fire_out_o       (fire_out)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [jdzt_pkg::Q15_W-1:0] clamp_q15(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[jdzt_pkg::Q15_W-1:0];
  endfunction

  // centre dead zone, edge of the zone maps to 0, ends of travel to -1 / +1
  function automatic logic signed [jdzt_pkg::Q15_W-1:0] stick_curve(
      logic signed [AW-1:0] pos, logic [jdzt_pkg::DZ_W-1:0] dz);
    longint v, t, span;
    v    = longint'(pos);
    t    = longint'(dz);
    span = Q_ONE - t;
    if (v < -t) return clamp_q15(-(((-(v + t)) * Q_ONE) / span));
    if (v < t) return '0;
    return clamp_q15(((v - t) * Q_ONE) / span);
  endfunction

  // low-end dead zone on a trigger, released reads -1
  function automatic longint trigger_curve(logic signed [AW-1:0] pos,
                                           logic [jdzt_pkg::DZ_W-1:0] dz);
    longint v, t, span, num;
    v    = longint'(pos);
    t    = longint'(dz);
    span = 2 * Q_ONE - t;
    if (v < t - Q_ONE) return -Q_ONE;
    num = 2 * v - t;
    if (num < 0) return clamp_q15(-(((-num) * Q_ONE) / span));
    return clamp_q15((num * Q_ONE) / span);
  endfunction

  function automatic command_t next_command(poll_t p);
    command_t c;
    longint   lvl;
    c.pitch = stick_curve(p.pitch, pitch_dz);
    c.roll  = stick_curve(p.roll, roll_dz);
    c.yaw   = clamp_q15((trigger_curve(p.yaw_r, yaw_dz) - trigger_curve(p.yaw_l, yaw_dz))
                        >>> 1);
    lvl = thrust_lvl;
    if (p.down && !down_held) lvl = lvl - longint'(thrust_step);
    down_held = p.down;
    if (lvl < 0) lvl = 0;
    if (p.up && !up_held) lvl = lvl + longint'(thrust_step);
    up_held = p.up;
    if (lvl > Q_ONE) lvl = Q_ONE;
    if (p.zero) lvl = 0;
    if (p.full) lvl = Q_ONE;
    thrust_lvl = lvl;
    c.thrust   = lvl[jdzt_pkg::Q15_W-1:0];
    c.fire     = p.fire;
    return c;
  endfunction

  // values around the dead-zone edges and the ends of travel, mixed with random ones
  function automatic logic signed [AW-1:0] pick_axis(logic [jdzt_pkg::DZ_W-1:0] dz,
                                                     bit trigger);
    int off;
    off = int'($urandom_range(0, 4)) - 2;
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3: return AW'($urandom);
      4, 5, 6: begin
        if (trigger) return AW'(longint'(dz) - Q_ONE + off);
        return AW'($urandom_range(0, 1) ? int'(dz) + off : -(int'(dz) + off));
      end
      7: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      8: return trigger ? 16'sh8000 : 16'sh0000;
      default: return AW'(int'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  task automatic queue_poll(logic signed [AW-1:0] roll, pitch, yaw_l, yaw_r,
                            int down, up, zero, full, fire);
    poll_t p;
    p.roll  = roll;
    p.pitch = pitch;
    p.yaw_l = yaw_l;
    p.yaw_r = yaw_r;
    p.down  = (down != 0);
    p.up    = (up != 0);
    p.zero  = (zero != 0);
    p.full  = (full != 0);
    p.fire  = (fire != 0);
    pending_polls.push_back(p);
  endtask

  // press and release patterns on the thrust buttons, overrides now and then
  task automatic queue_random(int unsigned count);
    poll_t p;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) gen_down = !gen_down;
      if ($urandom_range(0, 2) == 0) gen_up = !gen_up;
      p.roll  = pick_axis(roll_dz, 1'b0);
      p.pitch = pick_axis(pitch_dz, 1'b0);
      p.yaw_l = pick_axis(yaw_dz, 1'b1);
      p.yaw_r = pick_axis(yaw_dz, 1'b1);
      p.down  = gen_down;
      p.up    = gen_up;
      p.zero  = ($urandom_range(0, 11) == 0);
      p.full  = ($urandom_range(0, 15) == 0);
      p.fire  = ($urandom_range(0, 1) != 0);
      pending_polls.push_back(p);
    end
  endtask

  task automatic write_reg(logic [jdzt_pkg::CFG_IDX_W-1:0] idx,
                           logic [jdzt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      jdzt_pkg::REG_PITCH_DZ: pitch_dz = data[jdzt_pkg::DZ_W-1:0];
      jdzt_pkg::REG_YAW_DZ:   yaw_dz = data[jdzt_pkg::DZ_W-1:0];
      jdzt_pkg::REG_ROLL_DZ:  roll_dz = data[jdzt_pkg::DZ_W-1:0];
      jdzt_pkg::REG_STEP:     thrust_step = data[jdzt_pkg::STEP_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // sample at the falling edge, where the driver and the monitor are settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_polls.size() != 0 || in_valid || owed_commands.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic flag_error(string msg);
    n_errors++;
    $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // sender: one beat offered at a time, held until taken
  always @(posedge clk_i) begin
    bit took;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        owed_commands.push_back(next_command(cur));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_polls.size() != 0 && !quiet && $urandom_range(0, 6) == 0) begin
          gap_left <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          cur = pending_polls.pop_front();
          axis_roll  <= cur.roll;
          axis_pitch <= cur.pitch;
          axis_yl    <= cur.yaw_l;
          axis_yr    <= cur.yaw_r;
          btn_down   <= cur.down;
          btn_up     <= cur.up;
          btn_zero   <= cur.zero;
          btn_full   <= cur.full;
          btn_fire   <= cur.fire;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure: short bursts plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      burst_left <= 0;
      hold_left  <= 0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    command_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (owed_commands.size() == 0) begin
        flag_error("command beat with no poll outstanding");
      end else begin
        want = owed_commands.pop_front();
        if (pitch_out !== want.pitch)
          flag_error($sformatf("pitch got %0d want %0d", pitch_out, want.pitch));
        if (yaw_out !== want.yaw)
          flag_error($sformatf("yaw got %0d want %0d", yaw_out, want.yaw));
        if (roll_out !== want.roll)
          flag_error($sformatf("roll got %0d want %0d", roll_out, want.roll));
        if (thrust_out !== want.thrust)
          flag_error($sformatf("thrust got %0d want %0d", thrust_out, want.thrust));
        if (fire_out !== want.fire)
          flag_error($sformatf("fire got %0b want %0b", fire_out, want.fire));
        n_checked <= n_checked + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register defaults: dead-zone edges, trigger threshold, thrust lever cases
    @(negedge clk_i);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0);
    queue_poll(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 0, 1, 0, 0, 1);
    queue_poll(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 1, 0, 0, 0);
    queue_poll(16'sd3277, -16'sd6554, -16'sd22938, -16'sd22939, 0, 0, 0, 0, 0);
    queue_poll(-16'sd3278, 16'sd6553, -16'sd22939, -16'sd22938, 0, 1, 0, 0, 0);
    queue_poll(16'sd3278, -16'sd6555, 16'sh0000, 16'sh0000, 0, 0, 0, 0, 0);
    queue_poll(-16'sd3277, 16'sd6554, 16'sd1, -16'sd1, 0, 0, 0, 0, 0);
    queue_poll(16'sd3276, -16'sd6553, 16'sh8001, 16'sh7FFE, 1, 0, 0, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 1, 1, 0, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 1, 1, 0, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 0, 1, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 1, 0, 0, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 0, 0, 1, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 1, 0, 0, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 0, 1, 1, 0);
    queue_poll(16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 0, 0, 1, 0, 1);
    queue_poll(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 0, 0, 0, 0, 1);
    queue_poll(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1, 1, 0, 0, 0);
    queue_poll(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 0, 0, 0, 0, 0);
    wait_drained();

    // no dead zones, zero step: up and down presses must leave thrust alone
    write_reg(jdzt_pkg::REG_PITCH_DZ, 16'h0000);
    write_reg(jdzt_pkg::REG_YAW_DZ, 16'h0000);
    write_reg(jdzt_pkg::REG_ROLL_DZ, 16'h0000);
    write_reg(jdzt_pkg::REG_STEP, 16'h0000);
    @(negedge clk_i);
    queue_poll(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 0, 1, 0, 1, 0);
    queue_poll(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1, 0, 0, 0, 1);
    queue_poll(16'sd1, -16'sd1, 16'sh0000, 16'sh0000, 0, 1, 0, 0, 0);
    queue_random(90);
    wait_drained();

    // unused indexes ignored; widest zones through masking, step above full scale
    write_reg(REG_FIRST_UNUSED, 16'h1234);
    write_reg(REG_LAST_UNUSED, 16'h0001);
    write_reg(jdzt_pkg::REG_PITCH_DZ, 16'hFFFF);
    write_reg(jdzt_pkg::REG_YAW_DZ, 16'hFFFF);
    write_reg(jdzt_pkg::REG_ROLL_DZ, 16'hFFFF);
    write_reg(jdzt_pkg::REG_STEP, 16'hFFFF);
    @(negedge clk_i);
    queue_random(90);
    wait_drained();

    // full-scale step; hold the output side long enough to back up the input
    write_reg(jdzt_pkg::REG_PITCH_DZ, 16'd1);
    write_reg(jdzt_pkg::REG_YAW_DZ, 16'd32766);
    write_reg(jdzt_pkg::REG_ROLL_DZ, 16'd16384);
    write_reg(jdzt_pkg::REG_STEP, 16'h8000);
    @(negedge clk_i);
    queue_random(140);
    hold_armed = 1'b1;
    wait_drained();

    write_reg(jdzt_pkg::REG_PITCH_DZ, jdzt_pkg::CFG_DATA_W'($urandom));
    write_reg(jdzt_pkg::REG_YAW_DZ, jdzt_pkg::CFG_DATA_W'($urandom));
    write_reg(jdzt_pkg::REG_ROLL_DZ, jdzt_pkg::CFG_DATA_W'($urandom));
    write_reg(jdzt_pkg::REG_STEP, jdzt_pkg::CFG_DATA_W'($urandom_range(1, 8000)));
    @(negedge clk_i);
    queue_random(200);
    while (pending_polls.size() > QUIET_TAIL) @(negedge clk_i);
    quiet = 1'b1;
    wait_drained();
    repeat (POLL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d polls over %0d register writes, %0d commands compared.",
             n_sent, n_writes, n_checked);
    $display("Covered zone and step extremes, unused indexes, a %0d-cycle output hold-off.",
             LONG_HOLD);
    if (n_errors == 0 && owed_commands.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d polls sent, %0d commands compared.", n_sent, n_checked);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jdzt_pkg.sv
rtl/joystick_dead_zone_and_thrust_top.sv
test/tb_top.sv
